FILE: hdl/cac_pkg.sv
// Package for the address classifier: class codes, character constants and
// the per-byte character class record. Depends on nothing.
package cac_pkg;

  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  localparam int unsigned PAT_BTC  = 0;
  localparam int unsigned PAT_ETH  = 1;
  localparam int unsigned PAT_LTC  = 2;
  localparam int unsigned PAT_XRP  = 3;
  localparam int unsigned PAT_USDT = 4;
  localparam int unsigned NUM_PAT  = 5;

  typedef enum logic [2:0] {
    CLS_INVALID = 3'd0,
    CLS_BTC     = 3'd1,
    CLS_ETH     = 3'd2,
    CLS_LTC     = 3'd3,
    CLS_XRP     = 3'd4,
    CLS_USDT    = 3'd5
  } addr_class_t;

  typedef enum logic [1:0] {
    PFX_NONE    = 2'd0,
    PFX_SHORT   = 2'd1,
    PFX_PARTIAL = 2'd2,
    PFX_BC1     = 2'd3
  } prefix_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_L     = 8'h4c;
  localparam logic [7:0] CH_M     = 8'h4d;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic base58;
    logic hex;
    logic zero;
    logic one;
    logic three;
    logic upper_l;
    logic upper_m;
    logic upper_t;
    logic lower_b;
    logic lower_c;
    logic lower_r;
    logic lower_x;
  } char_class_t;

endpackage

FILE: hdl/cac_char_class.sv
// Character decoder for the address classifier: marks which classes and
// literal bytes the current character matches. Depends on cac_pkg.
module cac_char_class (
  input  logic [7:0]          character,
  output cac_pkg::char_class_t cls
);
  import cac_pkg::*;

  always_comb begin
    cls.base58  = (character >= 8'h31 && character <= 8'h39) ||
                  (character >= 8'h41 && character <= 8'h48) ||
                  (character >= 8'h4a && character <= 8'h4e) ||
                  (character >= 8'h50 && character <= 8'h5a) ||
                  (character >= 8'h61 && character <= 8'h6b) ||
                  (character >= 8'h6d && character <= 8'h7a);
    cls.hex     = (character >= 8'h30 && character <= 8'h39) ||
                  (character >= 8'h61 && character <= 8'h66) ||
                  (character >= 8'h41 && character <= 8'h46);
    cls.zero    = (character == CH_ZERO);
    cls.one     = (character == CH_ONE);
    cls.three   = (character == CH_THREE);
    cls.upper_l = (character == CH_L);
    cls.upper_m = (character == CH_M);
    cls.upper_t = (character == CH_T);
    cls.lower_b = (character == CH_B);
    cls.lower_c = (character == CH_C);
    cls.lower_r = (character == CH_R);
    cls.lower_x = (character == CH_X);
  end

endmodule

FILE: hdl/cac_tracker.sv
// Pattern tracker for the address classifier: holds the byte count, prefix
// state and live flags, and forms the class code used on the last byte.
// Depends on cac_pkg.
module cac_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 last,
  input  cac_pkg::char_class_t cls,
  output cac_pkg::addr_class_t result
);
  import cac_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  prefix_t            prefix_r, prefix_nxt;
  logic [NUM_PAT-1:0] alive_r, alive_nxt;
  logic [NUM_PAT-1:0] kill;
  logic               first;

  always_comb begin
    first      = (count_r == '0);
    kill       = '0;
    prefix_nxt = prefix_r;

    if (alive_r[PAT_BTC]) begin
      if (first) begin
        if (cls.one || cls.three) begin
          prefix_nxt = PFX_SHORT;
        end else if (cls.lower_b) begin
          prefix_nxt = PFX_PARTIAL;
        end else begin
          kill[PAT_BTC] = 1'b1;
        end
      end else if (prefix_r == PFX_PARTIAL) begin
        if (count_r == COUNT_W'(1)) begin
          kill[PAT_BTC] = !cls.lower_c;
        end else if (cls.one) begin
          prefix_nxt = PFX_BC1;
        end else begin
          kill[PAT_BTC] = 1'b1;
        end
      end else begin
        kill[PAT_BTC] = !cls.base58;
      end
    end

    if (first) begin
      kill[PAT_ETH] = !cls.zero;
    end else if (count_r == COUNT_W'(1)) begin
      kill[PAT_ETH] = !cls.lower_x;
    end else begin
      kill[PAT_ETH] = !cls.hex;
    end

    kill[PAT_LTC]  = first ? !(cls.upper_l || cls.upper_m) : !cls.base58;
    kill[PAT_XRP]  = first ? !cls.lower_r : !cls.base58;
    kill[PAT_USDT] = first ? !cls.upper_t : !cls.base58;

    alive_nxt = alive_r & ~kill;
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

    if (alive_nxt[PAT_BTC] && prefix_nxt == PFX_SHORT &&
        count_nxt >= COUNT_W'(26) && count_nxt <= COUNT_W'(35)) begin
      result = CLS_BTC;
    end else if (alive_nxt[PAT_BTC] && prefix_nxt == PFX_BC1 &&
                 count_nxt >= COUNT_W'(28) && count_nxt <= COUNT_W'(37)) begin
      result = CLS_BTC;
    end else if (alive_nxt[PAT_ETH] && count_nxt == COUNT_W'(42)) begin
      result = CLS_ETH;
    end else if (alive_nxt[PAT_LTC] && count_nxt >= COUNT_W'(26) &&
                 count_nxt <= COUNT_W'(35)) begin
      result = CLS_LTC;
    end else if (alive_nxt[PAT_XRP] && count_nxt == COUNT_W'(34)) begin
      result = CLS_XRP;
    end else if (alive_nxt[PAT_USDT] && count_nxt == COUNT_W'(34)) begin
      result = CLS_USDT;
    end else begin
      result = CLS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      prefix_r <= PFX_NONE;
      alive_r  <= '1;
    end else if (accept) begin
      if (last) begin
        count_r  <= '0;
        prefix_r <= PFX_NONE;
        alive_r  <= '1;
      end else begin
        count_r  <= count_nxt;
        prefix_r <= prefix_nxt;
        alive_r  <= alive_nxt;
      end
    end
  end

endmodule

FILE: hdl/crypto_address_classifier.sv
// Address classifier top level: one byte per transaction in, one class code
// out after the last byte; out_tvalid rises in the cycle after it is accepted.
// Throughput is one byte per cycle while the output register can take a result.
// A result waiting in the output register holds off the input until it is taken.
// Synchronous active-low reset clears the tracker to its start state and
// empties the output register. Depends on cac_pkg, cac_char_class, cac_tracker.
module crypto_address_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] address_class, [7:3] zero
);
  import cac_pkg::*;

  char_class_t cls;
  addr_class_t result;
  addr_class_t class_r;
  logic        valid_r;
  logic        accept;

  assign in_tready = !valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  cac_char_class u_char_class (
    .character (in_tdata),
    .cls       (cls)
  );

  cac_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .last   (in_tlast),
    .cls    (cls),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept && in_tlast) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      class_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b0, class_r};

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("last byte did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] <= 8'd5))
    else $error("class code out of range");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");
`endif

endmodule
